[rtl/rsb_pkg.sv]
// ----------------------------------------------------------------------------
// rsb_pkg
// Shared types and constants for the restart supervisor with backoff.
// ----------------------------------------------------------------------------
package rsb_pkg;

	localparam int FRACTION_BITS_DEF    = 8;
	localparam int TICKS_PER_SECOND_DEF = 1000;

	localparam int DELAY_W   = 24;
	localparam int MULT_W    = 16;
	localparam int WINDOW_W  = 16;
	localparam int COUNT_W   = 8;
	localparam int CODE_W    = 8;
	localparam int CFG_W     = 24;
	localparam int CFG_ADDR_W = 3;

	typedef enum logic [1:0] {
		MODE_TICK  = 2'd0,
		MODE_EXIT  = 2'd1,
		MODE_SPAWN = 2'd2
	} mode_t;

	typedef enum logic [1:0] {
		POLICY_NEVER   = 2'd0,
		POLICY_ALWAYS  = 2'd1,
		POLICY_ON_FAIL = 2'd2
	} policy_t;

	typedef enum logic [3:0] {
		ST_NONE      = 4'd0,
		ST_STARTED   = 4'd1,
		ST_SCHEDULED = 4'd2,
		ST_DUE       = 4'd3,
		ST_ESCALATED = 4'd4,
		ST_HELD      = 4'd5,
		ST_DECLINED  = 4'd6,
		ST_NO_POLICY = 4'd7,
		ST_IGNORED   = 4'd8
	} status_t;

	typedef enum logic [CFG_ADDR_W-1:0] {
		REG_POLICY     = 3'd0,
		REG_INITIAL_MS = 3'd1,
		REG_MULTIPLIER = 3'd2,
		REG_MAX_MS     = 3'd3,
		REG_WINDOW_SEC = 3'd4,
		REG_MAX_RESTARTS = 3'd5
	} reg_idx_t;

	localparam logic [1:0]          POLICY_RST      = 2'd0;
	localparam logic [DELAY_W-1:0]  INITIAL_MS_RST  = 24'd1000;
	localparam logic [MULT_W-1:0]   MULTIPLIER_RST  = 16'd512;
	localparam logic [DELAY_W-1:0]  MAX_MS_RST      = 24'd60000;
	localparam logic [WINDOW_W-1:0] WINDOW_SEC_RST  = 16'd60;
	localparam logic [COUNT_W-1:0]  MAX_RESTARTS_RST = 8'd5;

endpackage

[rtl/restart_supervisor_with_backoff.sv]
// ----------------------------------------------------------------------------
// restart_supervisor_with_backoff
// Supervises one restartable worker: tracking, restart window, escalation,
// capped exponential backoff and countdown of a pending restart.
// ----------------------------------------------------------------------------
// Every request (tick, exit or spawn) produces exactly one response. A request
// is taken every cycle while the response register is free or being drained;
// its response appears in the next cycle. All state is updated in the accepting
// cycle; the longest path is the exit request, which runs the running backoff
// product through a (24+FRACTION_BITS) x 16 multiplier and the cap compare.
// No clearing pass follows reset. Configuration writes take effect at once
// and are meant to be done while no request is in flight.
module restart_supervisor_with_backoff
	import rsb_pkg::*;
#(
	parameter int FRACTION_BITS    = FRACTION_BITS_DEF,
	parameter int TICKS_PER_SECOND = TICKS_PER_SECOND_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	input  logic [7:0]            s_axis_tdata,   // [7:0] code
	input  logic [1:0]            s_axis_tuser,   // [1:0] mode
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	output logic [39:0]           m_axis_tdata,   // [23:0] delay_ms, [31:24] restart_total,
	                                              // [39:32] code_echo
	output logic [3:0]            m_axis_tuser,   // [3:0] status
	input  logic                  cfg_wen,
	input  logic [CFG_ADDR_W-1:0] cfg_addr,
	input  logic [CFG_W-1:0]      cfg_wdata
);

	localparam int GW     = DELAY_W + FRACTION_BITS;
	localparam int PROD_W = GW + MULT_W;
	localparam int GROWN_W = PROD_W - FRACTION_BITS;
	localparam int MS_W   = (TICKS_PER_SECOND > 1) ? $clog2(TICKS_PER_SECOND) : 1;
	localparam logic [MS_W:0] TPS_C = (MS_W+1)'(TICKS_PER_SECOND);

	// configuration
	logic [1:0]          policy_q;
	logic [DELAY_W-1:0]  initial_q;
	logic [MULT_W-1:0]   mult_q;
	logic [DELAY_W-1:0]  max_q;
	logic [WINDOW_W-1:0] window_q;
	logic [COUNT_W-1:0]  max_restarts_q;

	// supervisor state
	logic                tracking_q, tracking_d;
	logic [MS_W-1:0]     ms_q, ms_d;
	logic [WINDOW_W-1:0] sec_q, sec_d;
	logic [COUNT_W-1:0]  cnt_q, cnt_d;
	logic [COUNT_W-1:0]  streak_q, streak_d;
	logic                esc_q, esc_d;
	logic [GW-1:0]       growing_q, growing_d;
	logic                sat_q, sat_d;
	logic                pending_q, pending_d;
	logic [DELAY_W-1:0]  pend_ms_q, pend_ms_d;

	// response register
	logic                m_valid_q;
	status_t             status_q, status_d;
	logic [DELAY_W-1:0]  delay_q, delay_d;
	logic [COUNT_W-1:0]  count_q;
	logic [CODE_W-1:0]   echo_q, echo_d;

	logic                accept;
	mode_t               mode;
	logic [CODE_W-1:0]   code;
	logic [PROD_W-1:0]   prod;
	logic [GROWN_W-1:0]  grown;
	logic [GW-1:0]       cap;

	assign s_axis_tready = !m_valid_q || m_axis_tready;
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign mode          = mode_t'(s_axis_tuser);
	assign code          = s_axis_tdata;

	assign prod  = PROD_W'(growing_q) * PROD_W'(mult_q);
	assign grown = prod[PROD_W-1:FRACTION_BITS];
	assign cap   = {max_q, {FRACTION_BITS{1'b0}}};

	always_comb begin
		logic [MS_W:0]      ms_inc;
		logic               go;
		logic               expired;
		logic [COUNT_W-1:0] streak_w;
		logic               sat_w;

		tracking_d = tracking_q;
		ms_d       = ms_q;
		sec_d      = sec_q;
		cnt_d      = cnt_q;
		streak_d   = streak_q;
		esc_d      = esc_q;
		growing_d  = growing_q;
		sat_d      = sat_q;
		pending_d  = pending_q;
		pend_ms_d  = pend_ms_q;
		status_d   = ST_NONE;
		delay_d    = '0;
		echo_d     = '0;
		ms_inc     = {1'b0, ms_q} + (MS_W+1)'(1);
		go         = (policy_q == POLICY_ALWAYS) ||
		             ((policy_q == POLICY_ON_FAIL) && (code != '0));
		expired    = (sec_q >= window_q);
		streak_w   = expired ? '0 : streak_q;
		sat_w      = expired ? 1'b0 : sat_q;

		case (mode)
			MODE_TICK: begin
				if (tracking_q) begin
					if (ms_inc >= TPS_C) begin
						ms_d = '0;
						if (sec_q != '1)
							sec_d = sec_q + 1'b1;
					end else begin
						ms_d = ms_inc[MS_W-1:0];
					end
				end
				if (pending_q) begin
					if (pend_ms_q <= DELAY_W'(1)) begin
						pending_d = 1'b0;
						pend_ms_d = '0;
						status_d  = ST_DUE;
					end else begin
						pend_ms_d = pend_ms_q - 1'b1;
					end
				end
			end
			MODE_EXIT: begin
				if (!tracking_q) begin
					status_d = ST_NO_POLICY;
				end else if (!go) begin
					tracking_d = 1'b0;
					ms_d       = '0;
					sec_d      = '0;
					cnt_d      = '0;
					streak_d   = '0;
					esc_d      = 1'b0;
					growing_d  = '0;
					sat_d      = 1'b0;
					pending_d  = 1'b0;
					pend_ms_d  = '0;
					status_d   = ST_DECLINED;
				end else begin
					if (expired) begin
						ms_d  = '0;
						sec_d = '0;
						cnt_d = '0;
					end
					streak_d = streak_w;
					sat_d    = sat_w;
					if ((expired ? '0 : cnt_q) >= max_restarts_q) begin
						if (!esc_q) begin
							esc_d    = 1'b1;
							status_d = ST_ESCALATED;
							echo_d   = code;
						end else begin
							status_d = ST_HELD;
						end
					end else begin
						if (streak_w == '0) begin
							growing_d = {initial_q, {FRACTION_BITS{1'b0}}};
							sat_d     = 1'b0;
							delay_d   = (initial_q < max_q) ? initial_q : max_q;
						end else begin
							if (!sat_w) begin
								if (grown >= GROWN_W'(cap)) begin
									sat_d     = 1'b1;
									growing_d = cap;
								end else begin
									growing_d = grown[GW-1:0];
								end
							end
							delay_d = sat_d ? max_q : growing_d[GW-1:FRACTION_BITS];
						end
						pending_d = 1'b1;
						pend_ms_d = delay_d;
						if (cnt_d != '1)
							cnt_d = cnt_d + 1'b1;
						if (streak_w != '1)
							streak_d = streak_w + 1'b1;
						status_d = ST_SCHEDULED;
						echo_d   = code;
					end
				end
			end
			MODE_SPAWN: begin
				if ((policy_q != POLICY_NEVER) && !tracking_q) begin
					tracking_d = 1'b1;
					ms_d       = '0;
					sec_d      = '0;
					cnt_d      = '0;
					streak_d   = '0;
					esc_d      = 1'b0;
					growing_d  = '0;
					sat_d      = 1'b0;
					pending_d  = 1'b0;
					pend_ms_d  = '0;
					status_d   = ST_STARTED;
				end
			end
			default: begin
				status_d = ST_IGNORED;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			policy_q       <= POLICY_RST;
			initial_q      <= INITIAL_MS_RST;
			mult_q         <= MULTIPLIER_RST;
			max_q          <= MAX_MS_RST;
			window_q       <= WINDOW_SEC_RST;
			max_restarts_q <= MAX_RESTARTS_RST;
		end else if (cfg_wen) begin
			case (reg_idx_t'(cfg_addr))
				REG_POLICY:       policy_q       <= cfg_wdata[1:0];
				REG_INITIAL_MS:   initial_q      <= cfg_wdata[DELAY_W-1:0];
				REG_MULTIPLIER:   mult_q         <= cfg_wdata[MULT_W-1:0];
				REG_MAX_MS:       max_q          <= cfg_wdata[DELAY_W-1:0];
				REG_WINDOW_SEC:   window_q       <= cfg_wdata[WINDOW_W-1:0];
				REG_MAX_RESTARTS: max_restarts_q <= cfg_wdata[COUNT_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tracking_q <= 1'b0;
			ms_q       <= '0;
			sec_q      <= '0;
			cnt_q      <= '0;
			streak_q   <= '0;
			esc_q      <= 1'b0;
			growing_q  <= '0;
			sat_q      <= 1'b0;
			pending_q  <= 1'b0;
			pend_ms_q  <= '0;
		end else if (accept) begin
			tracking_q <= tracking_d;
			ms_q       <= ms_d;
			sec_q      <= sec_d;
			cnt_q      <= cnt_d;
			streak_q   <= streak_d;
			esc_q      <= esc_d;
			growing_q  <= growing_d;
			sat_q      <= sat_d;
			pending_q  <= pending_d;
			pend_ms_q  <= pend_ms_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (accept) begin
			m_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			status_q <= status_d;
			delay_q  <= delay_d;
			count_q  <= cnt_d;
			echo_q   <= echo_d;
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tuser  = status_q;
	assign m_axis_tdata  = {echo_q, count_q, delay_q};

	a_idle_no_pending_time: assert property (@(posedge clk) disable iff (!arst_n)
		!pending_q |-> (pend_ms_q == '0))
		else $error("remaining delay nonzero with no restart pending");

	a_untracked_clean: assert property (@(posedge clk) disable iff (!arst_n)
		!tracking_q |-> (cnt_q == '0 && streak_q == '0 && !esc_q && !pending_q))
		else $error("supervisor state left over while not tracking");

	a_ms_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		{1'b0, ms_q} < TPS_C)
		else $error("millisecond part of window clock out of range");

	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> m_valid_q)
		else $error("request side stalled with empty response register");

endmodule

[bench/tb_restart_supervisor_with_backoff.sv]
// ----------------------------------------------------------------------------
// tb_restart_supervisor_with_backoff
// Self-checking bench for the restart supervisor. Requests (tick, exit,
// spawn, reserved mode) go in on the slave stream; a request-level predictor
// of the supervisor state computes each expected response, which the
// response monitor compares field by field in order. Directed tests cover
// reset defaults, all policies, delay and limit extremes and window
// rollover; random phases then vary every register, with idle bursts on
// both sides in randomly chosen phases, never in the closing ones.
// ----------------------------------------------------------------------------
module tb_restart_supervisor_with_backoff
	import rsb_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [1:0]            MODE_RESERVED   = 2'd3;
	localparam logic [1:0]            POLICY_RESERVED = 2'd3;
	localparam logic [CFG_ADDR_W-1:0] REG_SPARE_6     = 3'd6;
	localparam logic [CFG_ADDR_W-1:0] REG_SPARE_7     = 3'd7;

	typedef struct packed {
		status_t              status;
		logic [DELAY_W-1:0]   delay_ms;
		logic [COUNT_W-1:0]   restart_total;
		logic [CODE_W-1:0]    code_echo;
	} supervisor_resp_t;

	logic                  clk;
	logic                  arst_n;
	logic                  s_axis_tvalid;
	logic                  s_axis_tready;
	logic [7:0]            s_axis_tdata;   // [7:0] code
	logic [1:0]            s_axis_tuser;   // [1:0] mode
	logic                  m_axis_tvalid;
	logic                  m_axis_tready;
	logic [39:0]           m_axis_tdata;   // [23:0] delay_ms, [31:24] restart_total,
	                                       // [39:32] code_echo
	logic [3:0]            m_axis_tuser;   // [3:0] status
	logic                  cfg_wen;
	logic [CFG_ADDR_W-1:0] cfg_addr;
	logic [CFG_W-1:0]      cfg_wdata;

	restart_supervisor_with_backoff u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.cfg_wen       (cfg_wen),
		.cfg_addr      (cfg_addr),
		.cfg_wdata     (cfg_wdata)
	);

	// register shadow
	logic [1:0]          cfg_policy;
	logic [DELAY_W-1:0]  cfg_initial;
	logic [MULT_W-1:0]   cfg_mult;
	logic [DELAY_W-1:0]  cfg_max;
	logic [WINDOW_W-1:0] cfg_window;
	logic [COUNT_W-1:0]  cfg_max_restarts;

	// supervisor state
	bit                  tracking;
	logic [9:0]          win_ms;
	logic [15:0]         win_sec;
	logic [7:0]          restarts;
	logic [7:0]          streak;
	bit                  escalated;
	logic [31:0]         delay_q;
	bit                  delay_sat;
	bit                  pending;
	logic [DELAY_W-1:0]  remaining_ms;

	supervisor_resp_t    expected_resp[$];
	int                  mismatch_count;
	bit                  gaps_on;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("tb_restart_supervisor_with_backoff: errors");
		$finish;
	end

	function automatic void drop_tracking();
		tracking     = 1'b0;
		win_ms       = '0;
		win_sec      = '0;
		restarts     = '0;
		streak       = '0;
		escalated    = 1'b0;
		delay_q      = '0;
		delay_sat    = 1'b0;
		pending      = 1'b0;
		remaining_ms = '0;
	endfunction

	function automatic supervisor_resp_t predict_supervisor(input logic [1:0] mode,
			input logic [7:0] code);
		supervisor_resp_t r;
		logic [63:0]      cap_q;
		logic [63:0]      prod;
		logic             go;
		r = '{status: ST_NONE, delay_ms: '0, restart_total: '0, code_echo: '0};
		case (mode)
			MODE_TICK: begin
				if (tracking) begin
					win_ms = win_ms + 10'd1;
					if (win_ms >= TICKS_PER_SECOND_DEF) begin
						win_ms = '0;
						if (win_sec != 16'hFFFF)
							win_sec = win_sec + 16'd1;
					end
				end
				if (pending) begin
					if (remaining_ms <= 1) begin
						pending      = 1'b0;
						remaining_ms = '0;
						r.status     = ST_DUE;
					end else begin
						remaining_ms = remaining_ms - 1'b1;
					end
				end
			end
			MODE_EXIT: begin
				if (!tracking) begin
					r.status = ST_NO_POLICY;
				end else begin
					go = (cfg_policy == POLICY_ALWAYS) ||
						(cfg_policy == POLICY_ON_FAIL && code != 8'd0);
					if (!go) begin
						drop_tracking();
						r.status = ST_DECLINED;
					end else begin
						if (win_sec >= cfg_window) begin
							win_ms    = '0;
							win_sec   = '0;
							restarts  = '0;
							streak    = '0;
							delay_sat = 1'b0;
						end
						if (restarts >= cfg_max_restarts) begin
							if (!escalated) begin
								escalated   = 1'b1;
								r.status    = ST_ESCALATED;
								r.code_echo = code;
							end else begin
								r.status = ST_HELD;
							end
						end else begin
							cap_q = 64'(cfg_max) << FRACTION_BITS_DEF;
							if (streak == 8'd0) begin
								delay_q    = 32'(cfg_initial) << FRACTION_BITS_DEF;
								delay_sat  = 1'b0;
								r.delay_ms = cfg_initial < cfg_max ? cfg_initial : cfg_max;
							end else begin
								if (!delay_sat) begin
									prod = (64'(delay_q) * 64'(cfg_mult)) >> FRACTION_BITS_DEF;
									if (prod >= cap_q) begin
										delay_sat = 1'b1;
										prod      = cap_q;
									end
									delay_q = prod[31:0];
								end
								r.delay_ms = delay_sat ? cfg_max :
									delay_q[FRACTION_BITS_DEF +: DELAY_W];
							end
							pending      = 1'b1;
							remaining_ms = r.delay_ms;
							if (restarts != 8'hFF)
								restarts = restarts + 8'd1;
							if (streak != 8'hFF)
								streak = streak + 8'd1;
							r.status    = ST_SCHEDULED;
							r.code_echo = code;
						end
					end
				end
			end
			MODE_SPAWN: begin
				if (cfg_policy != POLICY_NEVER && !tracking) begin
					drop_tracking();
					tracking = 1'b1;
					r.status = ST_STARTED;
				end
			end
			default: r.status = ST_IGNORED;
		endcase
		r.restart_total = restarts;
		return r;
	endfunction

	task automatic report_mismatch(input string what, input logic [39:0] got,
			input logic [39:0] want);
		mismatch_count++;
		if (mismatch_count <= 60)
			$display("%t mismatch %s: got %h expected %h", $realtime, what, got, want);
	endtask

	task automatic send_request(input logic [1:0] mode, input logic [7:0] code);
		if (gaps_on && $urandom_range(0, 5) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 11)) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= mode;
		s_axis_tdata  <= code;
		do @(posedge clk); while (!s_axis_tready);
		expected_resp.insert(expected_resp.size(), predict_supervisor(mode, code));
	endtask

	task automatic drain_responses();
		s_axis_tvalid <= 1'b0;
		for (int n = 0; n < 2000 && expected_resp.size() != 0; n++)
			@(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [CFG_W-1:0] val);
		drain_responses();
		cfg_wen   <= 1'b1;
		cfg_addr  <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_wen <= 1'b0;
		case (idx)
			REG_POLICY:       cfg_policy       = val[1:0];
			REG_INITIAL_MS:   cfg_initial      = val[DELAY_W-1:0];
			REG_MULTIPLIER:   cfg_mult         = val[MULT_W-1:0];
			REG_MAX_MS:       cfg_max          = val[DELAY_W-1:0];
			REG_WINDOW_SEC:   cfg_window       = val[WINDOW_W-1:0];
			REG_MAX_RESTARTS: cfg_max_restarts = val[COUNT_W-1:0];
			default: ;
		endcase
	endtask

	always @(posedge clk) begin
		supervisor_resp_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (expected_resp.size() == 0) begin
				report_mismatch("response with none expected", m_axis_tdata, '0);
			end else begin
				want = expected_resp.pop_front();
				if (m_axis_tuser !== want.status)
					report_mismatch("status", 40'(m_axis_tuser), 40'(want.status));
				if (m_axis_tdata[23:0] !== want.delay_ms)
					report_mismatch("delay_ms", 40'(m_axis_tdata[23:0]), 40'(want.delay_ms));
				if (m_axis_tdata[31:24] !== want.restart_total)
					report_mismatch("restart_total", 40'(m_axis_tdata[31:24]),
						40'(want.restart_total));
				if (m_axis_tdata[39:32] !== want.code_echo)
					report_mismatch("code_echo", 40'(m_axis_tdata[39:32]),
						40'(want.code_echo));
			end
		end
	end

	initial begin
		m_axis_tready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (gaps_on && $urandom_range(0, 7) == 0) begin
				m_axis_tready <= 1'b0;
				repeat ($urandom_range(1, 11)) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
		end
	end

	task automatic test_reset_defaults();
		send_request(MODE_SPAWN, 8'h00);
		send_request(MODE_EXIT, 8'h3C);
		send_request(MODE_TICK, 8'hFF);
		send_request(MODE_RESERVED, 8'h81);
		write_reg(REG_POLICY, POLICY_ALWAYS);
		send_request(MODE_SPAWN, 8'h00);
		send_request(MODE_SPAWN, 8'h00);
		send_request(MODE_EXIT, 8'hA5);
		send_request(MODE_EXIT, 8'h5A);
		send_request(MODE_TICK, 8'h00);
	endtask

	task automatic test_policies();
		write_reg(REG_POLICY, POLICY_ON_FAIL);
		send_request(MODE_EXIT, 8'h00);
		send_request(MODE_SPAWN, 8'h00);
		send_request(MODE_EXIT, 8'hFF);
		write_reg(REG_POLICY, POLICY_RESERVED);
		send_request(MODE_EXIT, 8'h01);
		send_request(MODE_SPAWN, 8'h00);
		write_reg(REG_POLICY, POLICY_NEVER);
		send_request(MODE_SPAWN, 8'h00);
		send_request(MODE_EXIT, 8'h80);
	endtask

	task automatic test_backoff_extremes();
		write_reg(REG_POLICY, POLICY_ALWAYS);
		write_reg(REG_INITIAL_MS, 24'hFFFFFF);
		write_reg(REG_MULTIPLIER, 16'hFFFF);
		write_reg(REG_MAX_MS, 24'hFFFFFF);
		write_reg(REG_WINDOW_SEC, 16'hFFFF);
		write_reg(REG_MAX_RESTARTS, 8'hFF);
		write_reg(REG_SPARE_6, 24'hFFFFFF);
		write_reg(REG_SPARE_7, 24'h000000);
		send_request(MODE_SPAWN, 8'h00);
		send_request(MODE_EXIT, 8'h11);
		send_request(MODE_EXIT, 8'h22);
		// zero delays, zero window, no restarts allowed
		write_reg(REG_INITIAL_MS, 24'd0);
		write_reg(REG_MULTIPLIER, 16'd0);
		write_reg(REG_MAX_MS, 24'd0);
		write_reg(REG_WINDOW_SEC, 16'd0);
		write_reg(REG_MAX_RESTARTS, 8'd0);
		send_request(MODE_EXIT, 8'h33);
		send_request(MODE_EXIT, 8'h44);
		write_reg(REG_MAX_RESTARTS, 8'd1);
		send_request(MODE_EXIT, 8'h55);
		send_request(MODE_TICK, 8'h00);
		// initial above cap, shrinking multiplier
		write_reg(REG_INITIAL_MS, 24'd200);
		write_reg(REG_MULTIPLIER, 16'd128);
		write_reg(REG_MAX_MS, 24'd100);
		write_reg(REG_WINDOW_SEC, 16'hFFFF);
		write_reg(REG_MAX_RESTARTS, 8'd8);
		send_request(MODE_EXIT, 8'h66);
		send_request(MODE_EXIT, 8'h77);
		send_request(MODE_EXIT, 8'h88);
	endtask

	task automatic test_window_rollover();
		write_reg(REG_POLICY, POLICY_NEVER);
		send_request(MODE_EXIT, 8'h01);
		write_reg(REG_POLICY, POLICY_ALWAYS);
		write_reg(REG_INITIAL_MS, 24'd2);
		write_reg(REG_MULTIPLIER, 16'd384);
		write_reg(REG_MAX_MS, 24'd5);
		write_reg(REG_WINDOW_SEC, 16'd1);
		write_reg(REG_MAX_RESTARTS, 8'd2);
		send_request(MODE_SPAWN, 8'h00);
		repeat (4) send_request(MODE_EXIT, 8'($urandom()));
		repeat (1005) send_request(MODE_TICK, 8'($urandom()));
		repeat (4) send_request(MODE_EXIT, 8'($urandom()));
		repeat (8) send_request(MODE_TICK, 8'($urandom()));
	endtask

	task automatic test_random_traffic();
		int         items;
		int         pick;
		logic [7:0] code;
		for (int phase = 0; phase < 15; phase++) begin
			gaps_on = phase < 12 && $urandom_range(0, 3) != 0;
			pick = $urandom_range(0, 7);
			write_reg(REG_POLICY, pick < 3 ? POLICY_ALWAYS : pick < 6 ? POLICY_ON_FAIL :
				pick == 6 ? POLICY_NEVER : POLICY_RESERVED);
			pick = $urandom_range(0, 9);
			write_reg(REG_INITIAL_MS, pick < 7 ? 24'($urandom_range(0, 12)) :
				pick < 9 ? 24'($urandom_range(0, 400)) : 24'($urandom()));
			pick = $urandom_range(0, 9);
			write_reg(REG_MULTIPLIER, pick < 6 ? 24'($urandom_range(0, 768)) :
				24'(16'($urandom())));
			pick = $urandom_range(0, 9);
			write_reg(REG_MAX_MS, pick < 7 ? 24'($urandom_range(0, 40)) :
				pick < 9 ? 24'($urandom_range(0, 2000)) : 24'($urandom()));
			pick = $urandom_range(0, 9);
			write_reg(REG_WINDOW_SEC, pick < 3 ? 24'd0 : pick < 7 ? 24'd1 :
				24'($urandom_range(0, 65535)));
			pick = $urandom_range(0, 9);
			write_reg(REG_MAX_RESTARTS, pick < 7 ? 24'($urandom_range(0, 8)) :
				pick < 9 ? 24'd255 : 24'($urandom_range(0, 255)));
			send_request(MODE_SPAWN, 8'($urandom()));
			items = 0;
			while (items < 30) begin
				pick = $urandom_range(0, 99);
				code = $urandom_range(0, 7) == 0 ? 8'd0 : 8'($urandom());
				if (pick < 62)
					send_request(MODE_TICK, code);
				else if (pick < 88)
					send_request(MODE_EXIT, code);
				else if (pick < 96)
					send_request(MODE_SPAWN, code);
				else
					send_request(MODE_RESERVED, code);
				if (pick < 96)
					items++;
			end
		end
	endtask

	initial begin
		arst_n        <= 1'b0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata  <= '0;
		s_axis_tuser  <= MODE_TICK;
		cfg_wen       <= 1'b0;
		cfg_addr      <= REG_POLICY;
		cfg_wdata     <= '0;
		mismatch_count = 0;
		gaps_on        = 1'b1;
		cfg_policy       = POLICY_RST;
		cfg_initial      = INITIAL_MS_RST;
		cfg_mult         = MULTIPLIER_RST;
		cfg_max          = MAX_MS_RST;
		cfg_window       = WINDOW_SEC_RST;
		cfg_max_restarts = MAX_RESTARTS_RST;
		drop_tracking();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_defaults();
		test_policies();
		test_backoff_extremes();
		test_window_rollover();
		test_random_traffic();

		drain_responses();
		repeat (5) @(posedge clk);
		if (expected_resp.size() != 0)
			report_mismatch("responses never arrived", 40'(expected_resp.size()), '0);
		if (mismatch_count == 0)
			$display("tb_restart_supervisor_with_backoff: clean");
		else
			$display("tb_restart_supervisor_with_backoff: errors");
		$finish;
	end

endmodule

[restart_supervisor_with_backoff.f]
rtl/rsb_pkg.sv
rtl/restart_supervisor_with_backoff.sv
bench/tb_restart_supervisor_with_backoff.sv
